// File: rtl/core/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// shared types, constants and the crc-8 byte update for the sync/length
// frame parser
// ----------------------------------------------------------------------------
package slcd_pkg;

  localparam int unsigned PAYLOAD_BYTES = 20;
  localparam int unsigned COUNT_W       = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [7:0] SYNC_FIRST  = 8'h5A;
  localparam logic [7:0] SYNC_SECOND = 8'hA5;
  localparam logic [7:0] LEN_BYTE    = 8'(PAYLOAD_BYTES);
  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  typedef enum logic [2:0] {
    PH_HUNT0 = 3'd0,
    PH_HUNT1 = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRC   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_CRC_ERR = 2'd2
  } status_t;

  // parser to top level: what the accepted item does
  typedef struct packed {
    logic    store_en;
    logic    res_valid;
    status_t status;
  } parse_ctl_t;

  typedef struct packed {
    logic        [31:0] sensor_id;
    logic        [31:0] sensor_kind;
    logic signed [31:0] reading;
    logic signed [63:0] time_ms;
  } payload_t;

  typedef struct packed {
    status_t  status;
    payload_t fields;
  } frame_result_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

// File: rtl/core/sync_len_crc8_deframer_core.sv
// ----------------------------------------------------------------------------
// sync_len_crc8_deframer_core
// sync pair / length / payload / crc-8 frame parser, one byte per item
// ----------------------------------------------------------------------------
// output: a result is registered in the result register (or in the skid stage
//   while the output stalls) when the crc byte (or bad length byte) is accepted
// throughput: one byte item per cycle, set by the phase and crc update done for
//   each byte; in_ready drops only while the skid stage holds a result
// reset: rst (synchronous) returns to the hunt, clears the byte count and
//   presets the crc to 0xff; payload bytes are not cleared
module sync_len_crc8_deframer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         frame_status,
  output logic [31:0]        sensor_id,
  output logic [31:0]        sensor_kind,
  output logic signed [31:0] reading,
  output logic signed [63:0] time_ms
);
  import slcd_pkg::*;

  logic          fire;
  parse_ctl_t    ctl;
  payload_t      fields;
  frame_result_t res;
  frame_result_t out_res;

  // an item is taken whenever the skid stage is free
  assign fire = in_valid && in_ready;

  // phase machine, byte count and running crc
  slcd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (rx_byte),
    .ctl     (ctl)
  );

  // payload bytes shift in during the data phase only
  slcd_payload u_payload (
    .clk      (clk),
    .store_en (ctl.store_en),
    .rx_byte  (rx_byte),
    .fields   (fields)
  );

  // the unpacked fields are only passed on for a good frame
  always_comb begin
    res.status = ctl.status;
    res.fields = (ctl.status == ST_GOOD) ? fields : '0;
  end

  // result register plus skid stage
  slcd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (ctl.res_valid),
    .res       (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign frame_status = out_res.status;
  assign sensor_id    = out_res.fields.sensor_id;
  assign sensor_kind  = out_res.fields.sensor_kind;
  assign reading      = out_res.fields.reading;
  assign time_ms      = out_res.fields.time_ms;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_status == ST_GOOD || frame_status == ST_BAD_LEN ||
                   frame_status == ST_CRC_ERR))
    else $error("invalid frame status on output");

  a_fields_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_status != ST_GOOD) |->
      (sensor_id == '0 && sensor_kind == '0 && reading == '0 && time_ms == '0))
    else $error("fields not cleared on a bad frame");

  a_result_needs_item: assert property (@(posedge clk) disable iff (rst)
    ctl.res_valid |-> fire)
    else $error("result raised without an accepted item");

endmodule

// File: rtl/core/slcd_parser.sv
// ----------------------------------------------------------------------------
// slcd_parser
// frame phase tracking, payload byte count and running crc
// ----------------------------------------------------------------------------
module slcd_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output slcd_pkg::parse_ctl_t ctl
);
  import slcd_pkg::*;

  phase_t               phase, phase_next;
  logic [COUNT_W-1:0]   byte_count, byte_count_next;
  logic [7:0]           running_crc, running_crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT0;
      byte_count  <= '0;
      running_crc <= CRC_INIT;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
    end
  end

  // next state
  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    if (fire) begin
      unique case (phase)
        PH_HUNT1: phase_next = (rx_byte == SYNC_SECOND) ? PH_LEN : PH_HUNT0;
        PH_LEN: begin
          if (rx_byte == LEN_BYTE) begin
            byte_count_next  = '0;
            running_crc_next = CRC_INIT;
            phase_next       = PH_DATA;
          end else begin
            phase_next = PH_HUNT0;
          end
        end
        PH_DATA: begin
          running_crc_next = crc8_update(running_crc, rx_byte);
          byte_count_next  = byte_count + COUNT_W'(1);
          if (byte_count == COUNT_W'(PAYLOAD_BYTES - 1)) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC:  phase_next = PH_HUNT0;
        default: phase_next = (rx_byte == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
      endcase
    end
  end

  // outputs
  always_comb begin
    ctl.store_en  = 1'b0;
    ctl.res_valid = 1'b0;
    ctl.status    = ST_GOOD;
    if (fire) begin
      unique case (phase)
        PH_LEN: begin
          ctl.res_valid = (rx_byte != LEN_BYTE);
          ctl.status    = ST_BAD_LEN;
        end
        PH_DATA: ctl.store_en = 1'b1;
        PH_CRC: begin
          ctl.res_valid = 1'b1;
          ctl.status    = (rx_byte == running_crc) ? ST_GOOD : ST_CRC_ERR;
        end
        default: ctl.store_en = 1'b0;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(PAYLOAD_BYTES))
    else $error("payload byte count out of range");

  a_store_no_result: assert property (@(posedge clk) disable iff (rst)
    !(ctl.store_en && ctl.res_valid))
    else $error("payload store and result in the same item");

  a_crc_after_full: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CRC) |-> (byte_count == COUNT_W'(PAYLOAD_BYTES)))
    else $error("crc phase entered before full payload");

endmodule

// File: rtl/core/slcd_payload.sv
// ----------------------------------------------------------------------------
// slcd_payload
// payload byte shift line and little-endian field unpacking
// ----------------------------------------------------------------------------
module slcd_payload (
  input  logic              clk,
  input  logic              store_en,
  input  logic [7:0]        rx_byte,
  output slcd_pkg::payload_t fields
);
  import slcd_pkg::*;

  // oldest byte ends up in entry 0 after a full payload
  logic [7:0] frame_bytes [PAYLOAD_BYTES];

  always_ff @(posedge clk) begin
    if (store_en) begin
      for (int i = 0; i < PAYLOAD_BYTES - 1; i++) begin
        frame_bytes[i] <= frame_bytes[i+1];
      end
      frame_bytes[PAYLOAD_BYTES-1] <= rx_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fields.sensor_id[8*i +: 8]   = frame_bytes[i];
      fields.sensor_kind[8*i +: 8] = frame_bytes[4 + i];
      fields.reading[8*i +: 8]     = frame_bytes[8 + i];
    end
    for (int i = 0; i < 8; i++) begin
      fields.time_ms[8*i +: 8] = frame_bytes[12 + i];
    end
  end

endmodule

// File: rtl/core/slcd_out_buf.sv
// ----------------------------------------------------------------------------
// slcd_out_buf
// result register with a skid stage for output back-pressure
// ----------------------------------------------------------------------------
module slcd_out_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   res_valid,
  input  slcd_pkg::frame_result_t res,
  output logic                   space,
  output logic                   out_valid,
  input  logic                   out_ready,
  output slcd_pkg::frame_result_t out_res
);
  import slcd_pkg::*;

  logic          skid_valid;
  frame_result_t skid;
  logic          load;

  assign space = !skid_valid;
  assign load  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output is empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !res_valid)
    else $error("new result while skid stage is full");

  a_skid_from_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled without a stall");

endmodule

// File: bench/tb_sync_len_crc8_deframer_core.sv
// ----------------------------------------------------------------------------
// tb_sync_len_crc8_deframer_core
// drives a received byte stream of good, corrupted and broken frames through
// the deframer, predicts every frame result in a scoreboard and checks each
// result field by field, with random idling on both handshakes
// ----------------------------------------------------------------------------
module tb_sync_len_crc8_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import slcd_pkg::*;

  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 37;

  // kinds of byte sequence the random part sends
  typedef enum int {
    SEQ_GOOD,
    SEQ_BAD_CRC,
    SEQ_BAD_LEN,
    SEQ_BAD_SYNC,
    SEQ_NOISE
  } seq_kind_t;

  // --------------------------------------------------------------------------
  // frame scoreboard: tracks the parser state, queues predicted results
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    phase_t        phase;
    logic [7:0]    payload [PAYLOAD_BYTES];
    int unsigned   count;
    logic [7:0]    crc;
    frame_result_t frames_due[$];
    int            errors;
    int            n_good;
    int            n_bad_len;
    int            n_crc_err;

    function new();
      phase     = PH_HUNT0;
      count     = 0;
      crc       = CRC_INIT;
      errors    = 0;
      n_good    = 0;
      n_bad_len = 0;
      n_crc_err = 0;
    endfunction

    // bit-serial crc-8 step, msb of the data byte first
    static function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
    endfunction

    // one accepted byte: advance the parser, queue a result at frame end
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      r = '0;
      case (phase)
        PH_HUNT1: begin
          // a wrong second sync byte is not retried as a first one
          phase = (b == SYNC_SECOND) ? PH_LEN : PH_HUNT0;
        end
        PH_LEN: begin
          if (b == LEN_BYTE) begin
            count = 0;
            crc   = CRC_INIT;
            phase = PH_DATA;
          end else begin
            phase    = PH_HUNT0;
            r.status = ST_BAD_LEN;
            frames_due.push_back(r);
          end
        end
        PH_DATA: begin
          payload[count] = b;
          crc            = crc_next(crc, b);
          count++;
          if (count >= PAYLOAD_BYTES) phase = PH_CRC;
        end
        PH_CRC: begin
          phase = PH_HUNT0;
          if (b != crc) begin
            r.status = ST_CRC_ERR;
          end else begin
            r.status = ST_GOOD;
            for (int i = 0; i < 4; i++) begin
              r.fields.sensor_id[8*i +: 8]   = payload[i];
              r.fields.sensor_kind[8*i +: 8] = payload[4 + i];
              r.fields.reading[8*i +: 8]     = payload[8 + i];
            end
            for (int i = 0; i < 8; i++) r.fields.time_ms[8*i +: 8] = payload[12 + i];
          end
          frames_due.push_back(r);
        end
        default: begin
          phase = (b == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
        end
      endcase
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // one accepted result against the oldest prediction
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (frames_due.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual status %0d",
                 $time, got.status);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      field_check("frame_status", 64'(want.status), 64'(got.status));
      field_check("sensor_id", 64'(want.fields.sensor_id), 64'(got.fields.sensor_id));
      field_check("sensor_kind", 64'(want.fields.sensor_kind), 64'(got.fields.sensor_kind));
      field_check("reading", 64'(unsigned'(want.fields.reading)),
                  64'(unsigned'(got.fields.reading)));
      field_check("time_ms", want.fields.time_ms, got.fields.time_ms);
      case (want.status)
        ST_GOOD:    n_good++;
        ST_BAD_LEN: n_bad_len++;
        default:    n_crc_err++;
      endcase
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte   = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         frame_status;
  logic [31:0]        sensor_id;
  logic [31:0]        sensor_kind;
  logic signed [31:0] reading;
  logic signed [63:0] time_ms;

  frame_scoreboard sb;
  int              n_sent = 0;
  int              cycles = 0;
  // no idling on either side while set
  logic            calm   = 1'b0;

  always #1 clk = ~clk;

  sync_len_crc8_deframer_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_status (frame_status),
    .sensor_id    (sensor_id),
    .sensor_kind  (sensor_kind),
    .reading      (reading),
    .time_ms      (time_ms)
  );

  // --------------------------------------------------------------------------
  // byte item driver
  // --------------------------------------------------------------------------
  // valid stays up across back-to-back items, so it is only lowered in a gap
  task automatic send_byte(input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    n_sent++;
  endtask

  // sync pair, length, 20 payload bytes, crc; each bad kind breaks one step
  task automatic send_frame(input seq_kind_t kind);
    logic [7:0] body [PAYLOAD_BYTES];
    logic [7:0] c;
    logic [7:0] b;
    logic       extreme;
    extreme = ($urandom_range(7) == 0);
    send_byte(SYNC_FIRST);
    if (kind == SEQ_BAD_SYNC) begin
      // wrong second sync byte, any value but the right one
      b = 8'($urandom_range(255));
      if (b == SYNC_SECOND) b = b ^ 8'h01;
      send_byte(b);
      return;
    end
    send_byte(SYNC_SECOND);
    if (kind == SEQ_BAD_LEN) begin
      b = 8'($urandom_range(255));
      if (b == LEN_BYTE) b = b + 8'd1;
      send_byte(b);
      return;
    end
    send_byte(LEN_BYTE);
    c = CRC_INIT;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      // some frames use only the field extremes
      if (extreme) begin
        case ($urandom_range(3))
          0:       body[i] = 8'h00;
          1:       body[i] = 8'hFF;
          2:       body[i] = 8'h80;
          default: body[i] = 8'h7F;
        endcase
      end else begin
        body[i] = 8'($urandom_range(255));
      end
      c = frame_scoreboard::crc_next(c, body[i]);
      send_byte(body[i]);
    end
    // corrupted check byte: flip at least one bit
    if (kind == SEQ_BAD_CRC) c = c ^ 8'($urandom_range(1, 255));
    send_byte(c);
  endtask

  // --------------------------------------------------------------------------
  // result side: check accepted results, stall at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_result_t got;
    if (out_valid && out_ready) begin
      got.status             = status_t'(frame_status);
      got.fields.sensor_id   = sensor_id;
      got.fields.sensor_kind = sensor_kind;
      got.fields.reading     = reading;
      got.fields.time_ms     = time_ms;
      sb.check_result(got);
    end
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               sb.frames_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] edge_frame [PAYLOAD_BYTES];
    logic [7:0] c;
    int         pick;
    int         n_noise;

    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // wrong second sync byte: the repeated 0x5a is not taken as a new start,
    // so the trailing 0xa5 falls in the hunt and is ignored
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    // bad length byte at the top of the byte range
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'hFF);
    // good frame: id all ones, kind zero, reading most negative, time most positive
    edge_frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(LEN_BYTE);
    c = CRC_INIT;
    foreach (edge_frame[i]) begin
      c = frame_scoreboard::crc_next(c, edge_frame[i]);
      send_byte(edge_frame[i]);
    end
    send_byte(c);

    // random part: mostly well-formed frames, the rest broken or noise
    while (n_sent < RANDOM_ITEMS) begin
      calm = (n_sent >= 700 && n_sent < 1000);
      pick = $urandom_range(99);
      if (pick < 60) begin
        send_frame(SEQ_GOOD);
      end else if (pick < 75) begin
        send_frame(SEQ_BAD_CRC);
      end else if (pick < 85) begin
        send_frame(SEQ_BAD_LEN);
      end else if (pick < 92) begin
        send_frame(SEQ_BAD_SYNC);
      end else begin
        // bytes between frames
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) send_byte(8'($urandom_range(255)));
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // drain the predicted results, then idle before the summary
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d bytes sent in %0d cycles", n_sent, cycles);
    $display("results checked: %0d good frames, %0d bad length, %0d crc mismatch",
             sb.n_good, sb.n_bad_len, sb.n_crc_err);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
